FILE: sv/assert_macros.svh
// Assertion macros shared by the trilinear sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property checked at every clock edge out of reset.
`define TGS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Overlapping implication checked at every clock edge out of reset.
`define TGS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every clock edge out of reset.
`define TGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tgs_pkg.sv
// Types, constants and blend function of the trilinear grid sampler.
package tgs_pkg;
	localparam int GRID_DIM = 32;
	localparam int CELL_W = $clog2(GRID_DIM);
	localparam int HALF_W = CELL_W - 1;
	localparam int BANK_AW = 3 * HALF_W;
	localparam int NUM_BANKS = 8;
	localparam int BANK_DEPTH = 1 << BANK_AW;
	localparam int FRAC_W = 17;
	localparam logic [CELL_W-1:0] CELL_TOP = CELL_W'(GRID_DIM - 2);
	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_INV_X = 3'd3;
	localparam logic [2:0] REG_INV_Y = 3'd4;
	localparam logic [2:0] REG_INV_Z = 3'd5;

	typedef struct packed {
		logic [CELL_W-1:0] cidx;
		logic [FRAC_W-1:0] frac;
	} loc_t;

	// floor((a*(1-t) + b*t + 0.5) / 1), all in Q16 weights
	function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic [FRAC_W-1:0] t);
		logic signed [17:0] wa;
		logic signed [17:0] wb;
		logic signed [33:0] pa;
		logic signed [33:0] pb;
		logic signed [34:0] s;
		wa = $signed({1'b0, ONE_Q16 - t});
		wb = $signed({1'b0, t});
		pa = a * wa;
		pb = b * wb;
		s = 35'(pa) + 35'(pb) + 35'sd32768;
		return s[31:16];
	endfunction
endpackage

FILE: sv/trilinear_grid_sampler_top.sv
// Trilinear grid sampler top: parity-banked grid store and blend pipeline.
// One transaction per cycle in, writes and queries alike; a query passes
// seven stages (subtract, multiply, clamp, corner read, then one stage per
// blend axis), the last of which loads the output register. The store
// is split into eight banks by the parity of i, j and k, so the eight
// corners of any cell sit in different banks and are read in the same
// cycle. The whole pipe holds while the output register is full and not
// taken.
`include "assert_macros.svh"
module trilinear_grid_sampler_top import tgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic        [14:0] grid_index,
	input  logic signed [15:0] grid_value,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic signed [31:0] query_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] interpolated_value
);
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic        [31:0] inv_x_q, inv_y_q, inv_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			inv_x_q <= 32'd65536;
			inv_y_q <= 32'd65536;
			inv_z_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_data;
				REG_ORIGIN_Y: origin_y_q <= cfg_data;
				REG_ORIGIN_Z: origin_z_q <= cfg_data;
				REG_INV_X:    inv_x_q <= cfg_data;
				REG_INV_Y:    inv_y_q <= cfg_data;
				REG_INV_Z:    inv_z_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	loc_t lx, ly, lz;

	tgs_locate u_loc_x (.clk, .arst_n, .en(adv), .coord(query_x), .origin(origin_x_q),
		.inv_voxel(inv_x_q), .loc(lx));
	tgs_locate u_loc_y (.clk, .arst_n, .en(adv), .coord(query_y), .origin(origin_y_q),
		.inv_voxel(inv_y_q), .loc(ly));
	tgs_locate u_loc_z (.clk, .arst_n, .en(adv), .coord(query_z), .origin(origin_z_q),
		.inv_voxel(inv_z_q), .loc(lz));

	// transaction control and write payload alongside the mapper stages
	logic        v_s1, v_s2, v_s3;
	opcode_t     op_s1, op_s2, op_s3;
	logic [14:0] idx_s1, idx_s2, idx_s3;
	logic [15:0] val_s1, val_s2, val_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= opcode_t'(opcode);
			idx_s1 <= grid_index;
			val_s1 <= grid_value;
			op_s2 <= op_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			op_s3 <= op_s2;
			idx_s3 <= idx_s2;
			val_s3 <= val_s2;
		end
	end

	// write: bank from index parities, address from the upper coordinate bits
	logic [2:0]         wbank;
	logic [BANK_AW-1:0] waddr;
	logic [NUM_BANKS-1:0] bank_we;
	logic [CELL_W-1:0]  wi, wj, wk;

	assign wi = idx_s3[0 +: CELL_W];
	assign wj = idx_s3[CELL_W +: CELL_W];
	assign wk = idx_s3[2*CELL_W +: CELL_W];
	assign wbank = {wk[0], wj[0], wi[0]};
	assign waddr = {wk[CELL_W-1:1], wj[CELL_W-1:1], wi[CELL_W-1:1]};

	logic signed [15:0] rd_s4 [NUM_BANKS];
	logic [CELL_W-1:0]  x1, y1, z1;

	assign x1 = lx.cidx + 1'b1;
	assign y1 = ly.cidx + 1'b1;
	assign z1 = lz.cidx + 1'b1;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [15:0]        mem [BANK_DEPTH];
		logic [CELL_W-1:0]  xa, ya, za;
		logic [BANK_AW-1:0] raddr;

		assign xa = (lx.cidx[0] == b[0]) ? lx.cidx : x1;
		assign ya = (ly.cidx[0] == b[1]) ? ly.cidx : y1;
		assign za = (lz.cidx[0] == b[2]) ? lz.cidx : z1;
		assign raddr = {za[CELL_W-1:1], ya[CELL_W-1:1], xa[CELL_W-1:1]};
		assign bank_we[b] = adv && v_s3 && op_s3 == OP_WRITE && wbank == 3'(b);

		always_ff @(posedge clk) begin
			if (bank_we[b]) begin
				mem[waddr] <= val_s3;
			end
			if (adv) begin
				rd_s4[b] <= mem[raddr];
			end
		end
	end

	// s4: corners in bank order, cell parities to unscramble them
	logic                 qv_s4, qv_s5, qv_s6, qv_s7;
	logic [2:0]           par_s4;
	logic [FRAC_W-1:0]    tx_s4, ty_s4, tz_s4, ty_s5, tz_s5, tz_s6;
	logic signed [15:0]   c00_s5, c10_s5, c01_s5, c11_s5, c0_s6, c1_s6, r_s7;

	function automatic logic signed [15:0] corner(input logic [2:0] par,
		input logic [2:0] d, input logic signed [15:0] rd [NUM_BANKS]);
		return rd[par ^ d];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s4 <= 1'b0;
			qv_s5 <= 1'b0;
			qv_s6 <= 1'b0;
			qv_s7 <= 1'b0;
		end else if (adv) begin
			qv_s4 <= v_s3 && op_s3 == OP_QUERY;
			qv_s5 <= qv_s4;
			qv_s6 <= qv_s5;
			qv_s7 <= qv_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			par_s4 <= {lz.cidx[0], ly.cidx[0], lx.cidx[0]};
			tx_s4 <= lx.frac;
			ty_s4 <= ly.frac;
			tz_s4 <= lz.frac;
			c00_s5 <= lerp(corner(par_s4, 3'b000, rd_s4), corner(par_s4, 3'b001, rd_s4), tx_s4);
			c10_s5 <= lerp(corner(par_s4, 3'b010, rd_s4), corner(par_s4, 3'b011, rd_s4), tx_s4);
			c01_s5 <= lerp(corner(par_s4, 3'b100, rd_s4), corner(par_s4, 3'b101, rd_s4), tx_s4);
			c11_s5 <= lerp(corner(par_s4, 3'b110, rd_s4), corner(par_s4, 3'b111, rd_s4), tx_s4);
			ty_s5 <= ty_s4;
			tz_s5 <= tz_s4;
			c0_s6 <= lerp(c00_s5, c10_s5, ty_s5);
			c1_s6 <= lerp(c01_s5, c11_s5, ty_s5);
			tz_s6 <= tz_s5;
			r_s7 <= lerp(c0_s6, c1_s6, tz_s6);
		end
	end

	assign out_valid = qv_s7;
	assign interpolated_value = r_s7;

	`TGS_ASSERT(a_one_bank_write, $onehot0(bank_we), "more than one bank written")
	`TGS_ASSERT_NEXT(a_query_reaches_out, adv && qv_s6, out_valid, "query lost before output")
	`TGS_ASSERT_IMPL(a_no_write_on_stall, !adv, bank_we == '0, "bank written during stall")
endmodule

FILE: sv/tgs_locate.sv
// Three-stage axis mapper: world coordinate to cell index and Q1.16 fraction.
`include "assert_macros.svh"
module tgs_locate import tgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [31:0] coord,
	input  logic signed [31:0] origin,
	input  logic        [31:0] inv_voxel,
	output loc_t               loc
);
	logic signed [32:0] d_s1;
	logic        [63:0] prod_s2;
	logic               neg_s2;
	loc_t               loc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_s1 <= '0;
			prod_s2 <= '0;
			neg_s2 <= 1'b0;
			loc_s3 <= '0;
		end else if (en) begin
			d_s1 <= 33'(coord) - 33'(origin);
			neg_s2 <= d_s1[32];
			prod_s2 <= 64'(d_s1[31:0]) * 64'(inv_voxel);
			if (neg_s2) begin
				loc_s3 <= '0;
			end else if (prod_s2[63:32] > 32'(CELL_TOP)) begin
				loc_s3.cidx <= CELL_TOP;
				loc_s3.frac <= ONE_Q16;
			end else begin
				loc_s3.cidx <= prod_s2[32 +: CELL_W];
				loc_s3.frac <= {1'b0, prod_s2[31:16]};
			end
		end
	end

	assign loc = loc_s3;

	`TGS_ASSERT_IMPL(a_full_frac_top_cell, loc_s3.frac[16],
		loc_s3.frac[15:0] == 16'd0 && loc_s3.cidx == CELL_TOP, "full fraction off top cell")
endmodule
